[src/dem_pkg.sv]
// Package for the dual encoder multi-turn unwrapper.
// Widths, slice positions and the lane status struct. No dependencies.
package dem_pkg;

  localparam int unsigned WORD_W     = 32;  // packed sample word
  localparam int unsigned READ_WIDTH = 10;  // bits per encoder reading
  localparam int unsigned LOW_BIT_A  = 6;   // channel zero slice position
  localparam int unsigned LOW_BIT_B  = 22;  // channel one slice position
  localparam int unsigned TURN_W     = 22;  // turn counter, two's complement
  localparam int unsigned POS_W      = 32;  // position and delta width
  localparam int unsigned RD_OUT_W   = 10;  // reading field width on the port

  // Jump threshold: half the reading range
  localparam int unsigned HALF = 2 ** (READ_WIDTH - 1);

  typedef logic [READ_WIDTH-1:0] reading_t;
  typedef logic [TURN_W-1:0]     turn_t;
  typedef logic [POS_W-1:0]      pos_t;

  // Lane result for one sample
  typedef struct packed {
    pos_t pos;
    pos_t dlt;
  } lane_res_t;

endpackage

[src/dem_ifs.sv]
// Valid/ready channel interfaces of the encoder unwrapper.
// Depends on dem_pkg for field widths.

interface dem_in_if;
  logic                       valid;
  logic                       ready;
  logic [dem_pkg::WORD_W-1:0] raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink   (input valid, input raw_word, output ready);
endinterface

interface dem_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [dem_pkg::POS_W-1:0] position_a;
  logic signed [dem_pkg::POS_W-1:0] position_b;
  logic signed [dem_pkg::POS_W-1:0] delta_a;
  logic signed [dem_pkg::POS_W-1:0] delta_b;
  logic [dem_pkg::RD_OUT_W-1:0]     reading_a;
  logic [dem_pkg::RD_OUT_W-1:0]     reading_b;

  modport source (output valid, output position_a, output position_b, output delta_a,
                  output delta_b, output reading_a, output reading_b, input ready);
  modport sink   (input valid, input position_a, input position_b, input delta_a,
                  input delta_b, input reading_a, input reading_b, output ready);
endinterface

interface dem_cfg_if;
  logic valid;
  logic ready;
  logic negate_second;

  modport source (output valid, output negate_second, input ready);
  modport sink   (input valid, input negate_second, output ready);
endinterface

[src/dem_lane.sv]
// One encoder channel: turn tracking, origin capture, position and delta.
// Depends on dem_pkg.
module dem_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,     // consume reading this cycle
  input  logic               first,    // first sample since reset
  input  dem_pkg::reading_t  reading,
  output dem_pkg::lane_res_t res
);

  dem_pkg::reading_t last_rd_r, last_rd_nxt;
  dem_pkg::turn_t    turn_r, turn_nxt;
  dem_pkg::pos_t     origin_r, origin_nxt;
  dem_pkg::pos_t     last_val_r, last_val_nxt;

  logic signed [dem_pkg::READ_WIDTH:0] change;
  dem_pkg::turn_t turn_new;
  dem_pkg::pos_t  turn_ext;
  dem_pkg::pos_t  val;

  always_comb begin
    change = $signed({1'b0, reading}) - $signed({1'b0, last_rd_r});
    // a jump above half range is a wrap in the other direction
    if (change > $signed((dem_pkg::READ_WIDTH+1)'(dem_pkg::HALF))) begin
      turn_new = turn_r - dem_pkg::TURN_W'(1);
    end else if (change < -$signed((dem_pkg::READ_WIDTH+1)'(dem_pkg::HALF))) begin
      turn_new = turn_r + dem_pkg::TURN_W'(1);
    end else begin
      turn_new = turn_r;
    end
    turn_ext = dem_pkg::POS_W'($signed(turn_new));
    val      = dem_pkg::POS_W'(reading) + (turn_ext << dem_pkg::READ_WIDTH);

    if (first) begin
      res.pos = '0;
      res.dlt = '0;
    end else begin
      res.pos = val - origin_r;
      res.dlt = val - last_val_r;  // equals pos minus previous pos
    end

    last_rd_nxt  = step ? reading  : last_rd_r;
    turn_nxt     = step ? turn_new : turn_r;
    last_val_nxt = step ? val      : last_val_r;
    origin_nxt   = (step && first) ? val : origin_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rd_r  <= '0;
      turn_r     <= '0;
      origin_r   <= '0;
      last_val_r <= '0;
    end else begin
      last_rd_r  <= last_rd_nxt;
      turn_r     <= turn_nxt;
      origin_r   <= origin_nxt;
      last_val_r <= last_val_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_turn_unit_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (turn_r == $past(turn_r)) || (turn_r == $past(turn_r) + dem_pkg::TURN_W'(1))
             || (turn_r == $past(turn_r) - dem_pkg::TURN_W'(1)))
    else $error("turn counter moved by more than one");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(turn_r) && $stable(last_rd_r) && $stable(last_val_r))
    else $error("lane state changed without a sample");

  a_origin_capture: assert property (@(posedge clk) disable iff (!rst_n)
    (step && first) |=> (origin_r == last_val_r))
    else $error("origin not captured from first unwrapped value");
`endif

endmodule

[src/dual_encoder_multiturn_unwrap.sv]
// Top level of the dual encoder multi-turn unwrapper: input register,
// two unwrap lanes, result register. Depends on dem_pkg, dem_ifs, dem_lane.
//
//  channel  dir  payload                                   accepted when
//  in_ch    in   raw_word[31:0]                            valid && ready
//  out_ch   out  position_a/b, delta_a/b (s32), reading_a/b valid && ready
//  cfg_ch   in   negate_second                             valid && ready
//
// One word per cycle sustained while out_ch stays ready; a result passes
// through the input register, then the result register, before it is presented.
// Lane state (turn counter, last reading) is read and written in the one
// stage between those registers, so back-to-back words see each other's update.
// rst_n is synchronous: pipeline empties, lane state clears, negate_second = 1.
// A stall on out_ch holds the result; in_ch still takes one word into the
// input register, then drops ready until the result moves.
// cfg_ch is always ready; write it only while the pipeline is empty.
module dual_encoder_multiturn_unwrap (
  input  logic  clk,
  input  logic  rst_n,
  dem_in_if.sink    in_ch,
  dem_out_if.source out_ch,
  dem_cfg_if.sink   cfg_ch
);

  // input stage
  logic                       s1_v_r, s1_v_nxt;
  logic [dem_pkg::WORD_W-1:0] s1_word_r, s1_word_nxt;

  // result stage
  logic                         s2_v_r, s2_v_nxt;
  dem_pkg::pos_t                pos_a_r, pos_a_nxt, pos_b_r, pos_b_nxt;
  dem_pkg::pos_t                dlt_a_r, dlt_a_nxt, dlt_b_r, dlt_b_nxt;
  logic [dem_pkg::RD_OUT_W-1:0] rd_a_r, rd_a_nxt, rd_b_r, rd_b_nxt;

  logic started_r, started_nxt;
  logic negate_r, negate_nxt;

  logic adv;      // input word moves into the result register
  logic in_take;  // input word accepted
  dem_pkg::reading_t  rd_a, rd_b;
  dem_pkg::lane_res_t res_a, res_b;

  assign adv     = s1_v_r && (!s2_v_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !s1_v_r || adv;
  assign cfg_ch.ready = 1'b1;

  assign rd_a = s1_word_r[dem_pkg::LOW_BIT_A +: dem_pkg::READ_WIDTH];
  assign rd_b = s1_word_r[dem_pkg::LOW_BIT_B +: dem_pkg::READ_WIDTH];

  dem_lane u_lane_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .first   (!started_r),
    .reading (rd_a),
    .res     (res_a)
  );

  dem_lane u_lane_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .first   (!started_r),
    .reading (rd_b),
    .res     (res_b)
  );

  always_comb begin
    s1_v_nxt    = in_take ? 1'b1 : (adv ? 1'b0 : s1_v_r);
    s1_word_nxt = in_take ? in_ch.raw_word : s1_word_r;

    s2_v_nxt    = adv ? 1'b1 : ((s2_v_r && out_ch.ready) ? 1'b0 : s2_v_r);
    started_nxt = started_r || adv;
    negate_nxt  = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.negate_second : negate_r;

    pos_a_nxt = pos_a_r;
    pos_b_nxt = pos_b_r;
    dlt_a_nxt = dlt_a_r;
    dlt_b_nxt = dlt_b_r;
    rd_a_nxt  = rd_a_r;
    rd_b_nxt  = rd_b_r;
    if (adv) begin
      pos_a_nxt = res_a.pos;
      dlt_a_nxt = res_a.dlt;
      // channel one is reported with its sign flipped when asked
      pos_b_nxt = negate_r ? (dem_pkg::POS_W'(0) - res_b.pos) : res_b.pos;
      dlt_b_nxt = negate_r ? (dem_pkg::POS_W'(0) - res_b.dlt) : res_b.dlt;
      rd_a_nxt  = dem_pkg::RD_OUT_W'(rd_a);
      rd_b_nxt  = dem_pkg::RD_OUT_W'(rd_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      started_r <= 1'b0;
      negate_r  <= 1'b1;
    end else begin
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      started_r <= started_nxt;
      negate_r  <= negate_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    s1_word_r <= s1_word_nxt;
    pos_a_r   <= pos_a_nxt;
    pos_b_r   <= pos_b_nxt;
    dlt_a_r   <= dlt_a_nxt;
    dlt_b_r   <= dlt_b_nxt;
    rd_a_r    <= rd_a_nxt;
    rd_b_r    <= rd_b_nxt;
  end

  assign out_ch.valid      = s2_v_r;
  assign out_ch.position_a = $signed(pos_a_r);
  assign out_ch.position_b = $signed(pos_b_r);
  assign out_ch.delta_a    = $signed(dlt_a_r);
  assign out_ch.delta_b    = $signed(dlt_b_r);
  assign out_ch.reading_a  = rd_a_r;
  assign out_ch.reading_b  = rd_b_r;

`ifndef NO_ASSERTIONS
  a_first_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !started_r) |=> (pos_a_r == '0) && (dlt_a_r == '0)
                            && (pos_b_r == '0) && (dlt_b_r == '0))
    else $error("first result not zero");

  a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_ch.valid)
    else $error("advanced word did not reach the result register");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_ch.ready)
    else $error("input not ready with empty input register");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r)
    else $error("started flag dropped without reset");
`endif

endmodule

[tb/sv/dem_unwrap_tb_pkg.sv]
// Checking side of the encoder unwrapper bench: per-channel unwrap predictor
// and the queue of predicted results. Depends on dem_pkg.
package dem_unwrap_tb_pkg;
  import dem_pkg::*;

  typedef struct {
    pos_t     position_a;
    pos_t     position_b;
    pos_t     delta_a;
    pos_t     delta_b;
    reading_t reading_a;
    reading_t reading_b;
  } unwrap_result_t;

  class unwrap_tracker;
    bit             negate_second;
    reading_t       last_reading[2];
    turn_t          turn_count[2];
    pos_t           origin[2];
    pos_t           last_position[2];
    bit             started;
    unwrap_result_t predicted_q[$];
    int             errors;
    int             samples;
    int             results;
    int             turn_steps;
    int             neg_samples[2];

    function new();
      negate_second = 1'b1;
      for (int ch = 0; ch < 2; ch++) begin
        last_reading[ch]  = '0;
        turn_count[ch]    = '0;
        origin[ch]        = '0;
        last_position[ch] = '0;
      end
      started = 1'b0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return predicted_q.size();
    endfunction

    // step one lane's turn counter and return its unwrapped value
    function pos_t unwrap_lane(int ch, reading_t rd);
      int    change;
      int    prev;
      int    cur;
      turn_t t;
      cur    = rd;
      prev   = last_reading[ch];
      change = cur - prev;
      t      = turn_count[ch];
      if (change > int'(HALF)) begin
        t = t - 1'b1;
        turn_steps++;
      end else if (change < -int'(HALF)) begin
        t = t + 1'b1;
        turn_steps++;
      end
      turn_count[ch]   = t;
      last_reading[ch] = rd;
      return pos_t'(rd) + ({{(POS_W-TURN_W){t[TURN_W-1]}}, t} << READ_WIDTH);
    endfunction

    function void take_sample(logic [WORD_W-1:0] word);
      reading_t       rd[2];
      pos_t           val[2];
      pos_t           pos[2];
      pos_t           dlt[2];
      unwrap_result_t r;
      rd[0] = word[LOW_BIT_A +: READ_WIDTH];
      rd[1] = word[LOW_BIT_B +: READ_WIDTH];
      for (int ch = 0; ch < 2; ch++) val[ch] = unwrap_lane(ch, rd[ch]);
      for (int ch = 0; ch < 2; ch++) begin
        if (!started) begin
          origin[ch] = val[ch];
          pos[ch]    = '0;
          dlt[ch]    = '0;
        end else begin
          pos[ch] = val[ch] - origin[ch];
          dlt[ch] = pos[ch] - last_position[ch];
        end
        last_position[ch] = pos[ch];
      end
      started = 1'b1;
      if (negate_second) begin
        pos[1] = -pos[1];
        dlt[1] = -dlt[1];
      end
      r.position_a = pos[0];
      r.position_b = pos[1];
      r.delta_a    = dlt[0];
      r.delta_b    = dlt[1];
      r.reading_a  = rd[0];
      r.reading_b  = rd[1];
      predicted_q.push_back(r);
      samples++;
      neg_samples[negate_second]++;
    endfunction

    task check_result(pos_t pa, pos_t pb, pos_t da, pos_t db,
                      reading_t ra, reading_t rb);
      unwrap_result_t e;
      if (predicted_q.size() == 0) begin
        report("result word with no sample pending");
        return;
      end
      e = predicted_q.pop_front();
      results++;
      if (pa !== e.position_a)
        report($sformatf("position_a got %0d exp %0d", $signed(pa), $signed(e.position_a)));
      if (pb !== e.position_b)
        report($sformatf("position_b got %0d exp %0d", $signed(pb), $signed(e.position_b)));
      if (da !== e.delta_a)
        report($sformatf("delta_a got %0d exp %0d", $signed(da), $signed(e.delta_a)));
      if (db !== e.delta_b)
        report($sformatf("delta_b got %0d exp %0d", $signed(db), $signed(e.delta_b)));
      if (ra !== e.reading_a)
        report($sformatf("reading_a got %0d exp %0d", ra, e.reading_a));
      if (rb !== e.reading_b)
        report($sformatf("reading_b got %0d exp %0d", rb, e.reading_b));
    endtask
  endclass

endpackage

[tb/sv/dual_encoder_multiturn_unwrap_test.sv]
// Top-level bench for dual_encoder_multiturn_unwrap: drives sample words and
// negate_second writes, checks each result word. Depends on dem_pkg, dem_ifs,
// dem_unwrap_tb_pkg and the RTL.
module dual_encoder_multiturn_unwrap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dem_pkg::*;
  import dem_unwrap_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest legal run
  localparam int HOLD_CYCLES = 80;      // long output stall for back-pressure
  localparam int RAND_WORDS  = 150;     // per random phase, three phases

  logic clk;
  logic rst_n;

  dem_in_if  in_ch();
  dem_out_if out_ch();
  dem_cfg_if cfg_ch();

  dual_encoder_multiturn_unwrap i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  unwrap_tracker tracker;

  // no-idle window for both sides, and output hold handshake
  bit calm;
  int holds_asked;
  int holds_served;
  int hold_left;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // All inputs known from time zero.
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.raw_word       = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.negate_second = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Monitors: everything sampled at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) tracker.take_sample(in_ch.raw_word);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result(out_ch.position_a, out_ch.position_b, out_ch.delta_a,
                           out_ch.delta_b, out_ch.reading_a, out_ch.reading_b);
  end

  // register write lands in the predictor at the same edge as in the block
  always @(posedge clk) begin
    if (rst_n && cfg_ch.valid && cfg_ch.ready) tracker.negate_second = cfg_ch.negate_second;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycles,
               tracker.pending());
      $display("dual_encoder_multiturn_unwrap verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Result-side ready. Random 11% stalls outside the calm window; a hold
  // request drops ready for HOLD_CYCLES, counted here, so the pipeline
  // fills and in_ch.ready must fall while the sender keeps offering.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (holds_served < holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // ---------------------------------------------------------------------
  // Drivers: called at a falling edge, return at a falling edge.
  // ---------------------------------------------------------------------
  task automatic send_sample(input logic [WORD_W-1:0] word);
    // each idle cycle drawn at 11%, repeated while the draw keeps hitting
    while (!calm && $urandom_range(99) < 11) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.raw_word <= word;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // quiesce: let the pipeline drain before touching the register
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_negate(input logic value);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.negate_second <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // place two readings into a word, other bits from fill
  function automatic logic [WORD_W-1:0] pack_readings(int ra, int rb,
                                                      logic [WORD_W-1:0] fill);
    logic [WORD_W-1:0] w;
    w = fill;
    w[LOW_BIT_A +: READ_WIDTH] = reading_t'(ra);
    w[LOW_BIT_B +: READ_WIDTH] = reading_t'(rb);
    return w;
  endfunction

  // Random phase: mostly smooth encoder motion (runs of constant-ish
  // velocity that roll over the reading range), some steps of exactly half
  // the range or just over it, some pure noise words.
  task automatic random_phase(input int count, input int calm_words, input bit do_hold);
    int ra;
    int rb;
    int va;
    int vb;
    int run;
    int kind;
    int sent;
    ra   = tracker.last_reading[0];
    rb   = tracker.last_reading[1];
    run  = 0;
    kind = 0;
    va   = 0;
    vb   = 0;
    sent = 0;
    while (sent < count) begin
      calm = (sent < calm_words);
      if (do_hold && sent == count / 2) holds_asked++;
      if (run == 0) begin
        run  = $urandom_range(8, 30);
        kind = $urandom_range(99);
        va   = $urandom_range(0, 800) - 400;
        vb   = $urandom_range(0, 800) - 400;
      end
      if (kind < 75) begin
        // smooth motion with jitter
        ra = (ra + va + $urandom_range(0, 20) - 10) & 32'h3FF;
        rb = (rb + vb + $urandom_range(0, 20) - 10) & 32'h3FF;
      end else if (kind < 88) begin
        // right at the turn threshold, either side, either direction
        ra = (ra + ($urandom_range(1) ? 1 : -1) * (512 + $urandom_range(1))) & 32'h3FF;
        rb = (rb + ($urandom_range(1) ? 1 : -1) * (512 + $urandom_range(1))) & 32'h3FF;
      end else begin
        ra = $urandom_range(1023);
        rb = $urandom_range(1023);
      end
      send_sample(pack_readings(ra, rb, $urandom()));
      run--;
      sent++;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    tracker = new();
    calm    = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, negate_second at its reset value of one.
    // First word: both readings 1023 against the cleared 0, so both turn
    // counters step down yet positions and deltas must be zero.
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0000_0000);                         // roll back up over zero
    send_sample(pack_readings(512, 512, 32'h0));        // exactly half: no step
    send_sample(pack_readings(0, 0, 32'hFFFF_FFFF));    // back down by half, stray bits set
    send_sample(pack_readings(513, 0, 32'h0));          // just over half up: turn down
    send_sample(pack_readings(0, 513, 32'h0));          // a back, b up
    send_sample(pack_readings(1023, 1, 32'h5555_5555));
    send_sample(pack_readings(1, 1023, 32'hAAAA_AAAA));
    send_sample(pack_readings(1, 1023, 32'h0));         // no motion: zero delta
    send_sample(pack_readings(600, 400, 32'h0));
    send_sample(pack_readings(87, 911, 32'h0));         // a falls just over half, b rises just under half
    send_sample(pack_readings(1023, 0, 32'h0));
    send_sample(pack_readings(0, 1023, 32'h0));
    drain();

    // A short directed run with the negation off.
    write_negate(1'b0);
    send_sample(pack_readings(1023, 1023, 32'h0));
    send_sample(pack_readings(0, 0, 32'hFFFF_FFFF));
    send_sample(pack_readings(513, 513, 32'h0));
    send_sample(pack_readings(1, 1, 32'h0));
    drain();

    // Random phases; the first has the calm window, the first two the long hold.
    random_phase(RAND_WORDS, 80, 1'b1);
    drain();
    write_negate(1'b1);
    random_phase(RAND_WORDS, 0, 1'b1);
    drain();
    write_negate(1'b0);
    random_phase(RAND_WORDS, 0, 1'b0);

    // Wait for the tail, then a few more cycles for anything stray.
    in_ch.valid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("covered %0d samples (%0d negated, %0d plain), %0d result words checked",
             tracker.samples, tracker.neg_samples[1], tracker.neg_samples[0],
             tracker.results);
    $display("turn counter steps seen: %0d, long output holds: %0d", tracker.turn_steps,
             holds_served);
    if (tracker.errors == 0) begin
      $display("dual_encoder_multiturn_unwrap verification clean");
    end else begin
      $display("dual_encoder_multiturn_unwrap verification failed");
    end
    $finish;
  end

endmodule
